// ===== hdl/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg - shared types and constants for the rational arithmetic reducer
// Operation codes, output widths and the state types of both sequencers.
// ----------------------------------------------------------------------------
package rar_pkg;

  // default operand width of one fraction part
  localparam int unsigned DATA_WIDTH_DEF = 16;

  // fixed result widths
  localparam int unsigned NUM_OUT_W = 33;
  localparam int unsigned DEN_OUT_W = 32;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_X,
    ST_MUL_D,
    ST_SUM,
    ST_START,
    ST_REDUCE,
    ST_HOLD
  } top_state_e;

  // gcd and divide sequencer
  typedef enum logic [2:0] {
    RD_IDLE,
    RD_GCD,
    RD_DIV_NUM,
    RD_DIV_DEN,
    RD_DONE
  } red_state_e;

endpackage

// ===== hdl/rar_reduce.sv =====
// ----------------------------------------------------------------------------
// rar_reduce - gcd reduction of a magnitude pair
// Binary gcd followed by two restoring divisions by the gcd, all stepping
// through one shared subtract and compare unit, one step per cycle.
// ----------------------------------------------------------------------------
module rar_reduce #(
  parameter int unsigned MAG_W = 2 * rar_pkg::DATA_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] num_i,
  input  logic [MAG_W-1:0] den_i,
  output logic             done_o,
  output logic [MAG_W-1:0] num_o,
  output logic [MAG_W-1:0] den_o
);

  localparam int unsigned K_W   = $clog2(MAG_W + 1);
  localparam int unsigned CNT_W = $clog2(MAG_W);

  rar_pkg::red_state_e state_q, state_d;

  logic [MAG_W-1:0] n_q, n_d, d_q, d_d;
  logic [MAG_W-1:0] u_q, u_d, v_q, v_d;
  logic [MAG_W-1:0] g_q, g_d, r_q, r_d;
  logic [MAG_W-1:0] dq_q, dq_d, qn_q, qn_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // shared subtract and compare unit
  logic [MAG_W:0]   sub_x, sub_y;
  logic [MAG_W+1:0] diff;
  logic             borrow;
  logic             u_zero;
  logic             div_last;
  logic             q_bit;
  logic [MAG_W-1:0] q_next;

  // operand select for the shared unit
  always_comb begin
    if (state_q == rar_pkg::RD_GCD) begin
      sub_x = {1'b0, u_q};
      sub_y = {1'b0, v_q};
    end else begin
      sub_x = {r_q, dq_q[MAG_W-1]};
      sub_y = {1'b0, g_q};
    end
  end

  assign diff     = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow   = diff[MAG_W+1];
  assign u_zero   = (u_q == '0);
  assign div_last = (cnt_q == CNT_W'(MAG_W - 1));
  assign q_bit    = ~borrow;
  assign q_next   = {dq_q[MAG_W-2:0], q_bit};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rar_pkg::RD_IDLE: begin
        if (start_i) state_d = rar_pkg::RD_GCD;
      end
      rar_pkg::RD_GCD: begin
        if (u_zero) state_d = rar_pkg::RD_DIV_NUM;
      end
      rar_pkg::RD_DIV_NUM: begin
        if (div_last) state_d = rar_pkg::RD_DIV_DEN;
      end
      rar_pkg::RD_DIV_DEN: begin
        if (div_last) state_d = rar_pkg::RD_DONE;
      end
      rar_pkg::RD_DONE: begin
        state_d = rar_pkg::RD_IDLE;
      end
      default: state_d = rar_pkg::RD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = (state_q == rar_pkg::RD_DONE);
    num_o  = qn_q;
    den_o  = dq_q;
  end

  // datapath step
  always_comb begin
    n_d   = n_q;
    d_d   = d_q;
    u_d   = u_q;
    v_d   = v_q;
    g_d   = g_q;
    r_d   = r_q;
    dq_d  = dq_q;
    qn_d  = qn_q;
    k_d   = k_q;
    cnt_d = cnt_q;
    unique case (state_q)
      rar_pkg::RD_IDLE: begin
        if (start_i) begin
          n_d = num_i;
          d_d = den_i;
          u_d = num_i;
          v_d = den_i;
          k_d = '0;
        end
      end
      rar_pkg::RD_GCD: begin
        priority if (u_zero) begin
          // v holds the odd part, put the common twos back
          g_d   = v_q << k_q;
          r_d   = '0;
          dq_d  = n_q;
          cnt_d = '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (borrow) begin
          // both odd, u smaller: swap so the larger one is reduced
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = diff[MAG_W-1:0];
        end
      end
      rar_pkg::RD_DIV_NUM, rar_pkg::RD_DIV_DEN: begin
        r_d   = q_bit ? diff[MAG_W-1:0] : sub_x[MAG_W-1:0];
        dq_d  = q_next;
        cnt_d = cnt_q + 1'b1;
        if (div_last && (state_q == rar_pkg::RD_DIV_NUM)) begin
          // numerator quotient done, load the denominator
          qn_d  = q_next;
          dq_d  = d_q;
          r_d   = '0;
          cnt_d = '0;
        end
      end
      rar_pkg::RD_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rar_pkg::RD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    u_q   <= u_d;
    v_q   <= v_d;
    g_q   <= g_d;
    r_q   <= r_d;
    dq_q  <= dq_d;
    qn_q  <= qn_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
  end

  // the gcd loop never sees a zero second operand
  a_gcd_v_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rar_pkg::RD_GCD) |-> (v_q != '0))
    else $error("gcd operand v reached zero");

  // partial remainder stays below the divisor
  a_rem_below_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rar_pkg::RD_DIV_NUM) || (state_q == rar_pkg::RD_DIV_DEN))
      |-> (r_q < g_q))
    else $error("partial remainder not below gcd");

  // a reduced denominator is never zero
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rar_pkg::RD_DONE) |-> (dq_q != '0))
    else $error("reduced denominator is zero");

endmodule

// ===== hdl/rational_arith_reduce_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit - fraction add, subtract, multiply, divide
// Forms the raw numerator and denominator with one shared multiplier and
// reduces them by their gcd; a zero denominator gives 0/0 with an error.
// ----------------------------------------------------------------------------
//  channel  valid        stall        word
//  input    in_valid_i   in_stall_o   op_i, a_num_i, a_den_i, b_num_i, b_den_i
//  output   out_valid_o  out_stall_i  res_num_o, res_den_o, div_error_o
//
//  one word at a time; in_stall_o is high from acceptance until the result
//  is loaded into the output register. for each word, W = 2*DATA_WIDTH, the
//  block runs the multiplies and sum, a data dependent number of binary gcd
//  steps (each swap, subtract and halve round drops a bit), 2*W division
//  steps and a finish; a zero denominator skips the gcd and the divisions.
//  the shared subtract unit in rar_reduce paces the gcd and division steps.
//  a stalled result waits in the output register while the next word is taken.
//  rst_ni is asynchronous and active low; it clears all control state.
// ----------------------------------------------------------------------------
module rational_arith_reduce_unit #(
  parameter int unsigned DATA_WIDTH = rar_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            op_i,
  input  logic signed [DATA_WIDTH-1:0]          a_num_i,
  input  logic signed [DATA_WIDTH-1:0]          a_den_i,
  input  logic signed [DATA_WIDTH-1:0]          b_num_i,
  input  logic signed [DATA_WIDTH-1:0]          b_den_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rar_pkg::NUM_OUT_W-1:0]  res_num_o,
  output logic signed [rar_pkg::DEN_OUT_W-1:0]  res_den_o,
  output logic                                  div_error_o
);

  localparam int unsigned MAG_W = 2 * DATA_WIDTH;
  localparam int unsigned NEXT_W = (MAG_W > rar_pkg::NUM_OUT_W) ? MAG_W : rar_pkg::NUM_OUT_W;
  localparam int unsigned DEXT_W = (MAG_W > rar_pkg::DEN_OUT_W) ? MAG_W : rar_pkg::DEN_OUT_W;

  // operand slots
  localparam int unsigned IDX_AN = 0;
  localparam int unsigned IDX_AD = 1;
  localparam int unsigned IDX_BN = 2;
  localparam int unsigned IDX_BD = 3;

  rar_pkg::top_state_e state_q, state_d;

  logic [3:0][DATA_WIDTH-1:0] in_raw, in_mag, mag_q;
  logic [3:0]                 in_neg, neg_q;
  rar_pkg::op_e               op_q;

  logic [DATA_WIDTH-1:0] mul_x, mul_y;
  logic [MAG_W-1:0]      prod;
  logic [MAG_W-1:0]      p1_q, p2_q, den_mag_q;
  logic [MAG_W-1:0]      num_mag_q, num_mag_d;
  logic                  num_neg_q, num_neg_d, den_neg_q, den_neg_d, err_q;

  logic t1_neg, t2_neg, same_sign, p1_ge;
  logic [MAG_W-1:0] sum_mag;
  logic             sum_neg;

  logic             accept, load_p1, load_p2, load_den, load_sum, red_start, load_out;
  logic             red_done;
  logic [MAG_W-1:0] red_num, red_den;

  logic [NEXT_W-1:0] num_ext, num_signed;
  logic [DEXT_W-1:0] den_ext, den_signed;
  logic [rar_pkg::NUM_OUT_W-1:0] res_num_d;
  logic [rar_pkg::DEN_OUT_W-1:0] res_den_d;
  logic out_valid_q, out_valid_d;
  logic [rar_pkg::NUM_OUT_W-1:0] res_num_q;
  logic [rar_pkg::DEN_OUT_W-1:0] res_den_q;
  logic div_error_q;

  // sign and magnitude of the four operands
  assign in_raw[IDX_AN] = a_num_i;
  assign in_raw[IDX_AD] = a_den_i;
  assign in_raw[IDX_BN] = b_num_i;
  assign in_raw[IDX_BD] = b_den_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_neg[i] = in_raw[i][DATA_WIDTH-1];
      in_mag[i] = in_neg[i] ? (~in_raw[i] + 1'b1) : in_raw[i];
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      rar_pkg::ST_MUL_N: begin
        mul_x = mag_q[IDX_AN];
        mul_y = (op_q == rar_pkg::OP_MUL) ? mag_q[IDX_BN] : mag_q[IDX_BD];
      end
      rar_pkg::ST_MUL_X: begin
        mul_x = mag_q[IDX_BN];
        mul_y = mag_q[IDX_AD];
      end
      default: begin
        mul_x = mag_q[IDX_AD];
        mul_y = (op_q == rar_pkg::OP_DIV) ? mag_q[IDX_BN] : mag_q[IDX_BD];
      end
    endcase
  end

  assign prod = mul_x * mul_y;

  // signed sum of the cross products
  always_comb begin
    t1_neg = (p1_q != '0) &&
             (neg_q[IDX_AN] ^ ((op_q == rar_pkg::OP_MUL) ? neg_q[IDX_BN] : neg_q[IDX_BD]));
    t2_neg = (p2_q != '0) &&
             (neg_q[IDX_BN] ^ neg_q[IDX_AD] ^ (op_q == rar_pkg::OP_SUB));
    same_sign = (t1_neg == t2_neg);
    p1_ge     = (p1_q >= p2_q);
    priority if (same_sign) begin
      sum_mag = p1_q + p2_q;
      sum_neg = t1_neg;
    end else if (p1_ge) begin
      sum_mag = p1_q - p2_q;
      sum_neg = t1_neg;
    end else begin
      sum_mag = p2_q - p1_q;
      sum_neg = t2_neg;
    end
    if (sum_mag == '0) sum_neg = 1'b0;

    if ((op_q == rar_pkg::OP_ADD) || (op_q == rar_pkg::OP_SUB)) begin
      num_mag_d = sum_mag;
      num_neg_d = sum_neg;
    end else begin
      num_mag_d = p1_q;
      num_neg_d = t1_neg;
    end
    den_neg_d = neg_q[IDX_AD] ^
                ((op_q == rar_pkg::OP_DIV) ? neg_q[IDX_BN] : neg_q[IDX_BD]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rar_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rar_pkg::ST_MUL_N;
      end
      rar_pkg::ST_MUL_N: begin
        if ((op_q == rar_pkg::OP_ADD) || (op_q == rar_pkg::OP_SUB)) begin
          state_d = rar_pkg::ST_MUL_X;
        end else begin
          state_d = rar_pkg::ST_MUL_D;
        end
      end
      rar_pkg::ST_MUL_X: state_d = rar_pkg::ST_MUL_D;
      rar_pkg::ST_MUL_D: state_d = rar_pkg::ST_SUM;
      rar_pkg::ST_SUM: begin
        if (den_mag_q == '0) begin
          state_d = rar_pkg::ST_HOLD;
        end else begin
          state_d = rar_pkg::ST_START;
        end
      end
      rar_pkg::ST_START: state_d = rar_pkg::ST_REDUCE;
      rar_pkg::ST_REDUCE: begin
        if (red_done) state_d = rar_pkg::ST_HOLD;
      end
      rar_pkg::ST_HOLD: begin
        if (!out_valid_q || !out_stall_i) state_d = rar_pkg::ST_IDLE;
      end
      default: state_d = rar_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != rar_pkg::ST_IDLE);
    accept     = in_valid_i && (state_q == rar_pkg::ST_IDLE);
    load_p1    = (state_q == rar_pkg::ST_MUL_N);
    load_p2    = (state_q == rar_pkg::ST_MUL_X);
    load_den   = (state_q == rar_pkg::ST_MUL_D);
    load_sum   = (state_q == rar_pkg::ST_SUM);
    red_start  = (state_q == rar_pkg::ST_START);
    load_out   = (state_q == rar_pkg::ST_HOLD) && (!out_valid_q || !out_stall_i);
  end

  rar_reduce #(
    .MAG_W (MAG_W)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .num_i   (num_mag_q),
    .den_i   (den_mag_q),
    .done_o  (red_done),
    .num_o   (red_num),
    .den_o   (red_den)
  );

  // put the signs back and wrap to the output widths
  always_comb begin
    num_ext    = NEXT_W'(red_num);
    den_ext    = DEXT_W'(red_den);
    num_signed = num_neg_q ? (~num_ext + 1'b1) : num_ext;
    den_signed = den_neg_q ? (~den_ext + 1'b1) : den_ext;
    if (err_q) begin
      res_num_d = '0;
      res_den_d = '0;
    end else begin
      res_num_d = num_signed[rar_pkg::NUM_OUT_W-1:0];
      res_den_d = den_signed[rar_pkg::DEN_OUT_W-1:0];
    end
  end

  // output word valid
  always_comb begin
    priority if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rar_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // operand, product and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q <= in_mag;
      neg_q <= in_neg;
      op_q  <= rar_pkg::op_e'(op_i);
    end
    if (load_p1) p1_q <= prod;
    if (load_p2) p2_q <= prod;
    if (load_den) den_mag_q <= prod;
    if (load_sum) begin
      num_mag_q <= num_mag_d;
      num_neg_q <= num_neg_d;
      den_neg_q <= den_neg_d;
      err_q     <= (den_mag_q == '0);
    end
    if (load_out) begin
      res_num_q   <= res_num_d;
      res_den_q   <= res_den_d;
      div_error_q <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign div_error_o = div_error_q;

  // a new output word only comes out of the hold state
  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == rar_pkg::ST_HOLD))
    else $error("output word raised outside hold state");

  // an error word carries 0/0
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_error_o) |-> ((res_num_o == '0) && (res_den_o == '0)))
    else $error("error word with nonzero fraction");

  // a taken word blocks the input until its result is out
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after acceptance");

endmodule

// ===== test/rational_arith_reduce_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit_test - checks the fraction reducer end to end
// Directed edge cases then random fractions go in through a queue-fed driver
// with random gaps. Each result is checked field by field against a
// predicted reduced fraction, under random back-pressure on the result side.
// ----------------------------------------------------------------------------
module rational_arith_reduce_unit_test;

  localparam int unsigned DW          = rar_pkg::DATA_WIDTH_DEF;
  localparam int unsigned RANDOM_WORDS = 950;
  localparam int unsigned END_WAIT    = 200;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    rar_pkg::op_e         op;
    logic signed [DW-1:0] a_num;
    logic signed [DW-1:0] a_den;
    logic signed [DW-1:0] b_num;
    logic signed [DW-1:0] b_den;
  } frac_word_t;

  typedef struct {
    frac_word_t                           src;
    logic signed [rar_pkg::NUM_OUT_W-1:0] num;
    logic signed [rar_pkg::DEN_OUT_W-1:0] den;
    logic                                 err;
  } frac_result_t;

  // clock, reset and block ports
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                                 in_valid_i  = 1'b0;
  logic                                 in_stall_o;
  logic [1:0]                           op_i        = rar_pkg::OP_ADD;
  logic signed [DW-1:0]                 a_num_i     = '0;
  logic signed [DW-1:0]                 a_den_i     = '0;
  logic signed [DW-1:0]                 b_num_i     = '0;
  logic signed [DW-1:0]                 b_den_i     = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [rar_pkg::NUM_OUT_W-1:0] res_num_o;
  logic signed [rar_pkg::DEN_OUT_W-1:0] res_den_o;
  logic                                 div_error_o;

  frac_word_t   word_q[$];
  frac_result_t fraction_q[$];

  bit word_taken    = 1'b0;
  bit res_taken     = 1'b0;
  int fail_count    = 0;
  int pushed_count  = 0;
  int checked_count = 0;

  always #5 clk_i = ~clk_i;

  rational_arith_reduce_unit #(
    .DATA_WIDTH (DW)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .div_error_o (div_error_o)
  );

  // euclid on magnitudes
  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // exact raw fraction, reduced by gcd, wrapped to the result widths
  function automatic frac_result_t reduce_fraction(frac_word_t w);
    frac_result_t    r;
    longint          an, ad, bn, bd, num, den;
    longint unsigned g;
    an = w.a_num;
    ad = w.a_den;
    bn = w.b_num;
    bd = w.b_den;
    r.src = w;
    case (w.op)
      rar_pkg::OP_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      rar_pkg::OP_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      rar_pkg::OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    if (den == 0) begin
      r.num = '0;
      r.den = '0;
      r.err = 1'b1;
      return r;
    end
    g = euclid_gcd((num < 0) ? -num : num, (den < 0) ? -den : den);
    num = num / longint'(g);
    den = den / longint'(g);
    r.num = rar_pkg::NUM_OUT_W'(num);
    r.den = rar_pkg::DEN_OUT_W'(den);
    r.err = 1'b0;
    return r;
  endfunction

  // one fraction part: full range, small, extremes or power-of-two multiples
  function automatic logic signed [DW-1:0] pick_part();
    int sel;
    int sv;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      sv = int'($urandom);
    end else if (sel < 7) begin
      sv = int'($urandom_range(0, 40)) - 20;
    end else if (sel < 9) begin
      sv = (int'($urandom_range(0, 12)) - 6) * (1 << $urandom_range(0, 9));
    end else begin
      case ($urandom_range(0, 5))
        0:       sv = -32768;
        1:       sv = -32767;
        2:       sv = 32767;
        3:       sv = 0;
        4:       sv = 1;
        default: sv = -1;
      endcase
    end
    return DW'(sv);
  endfunction

  task automatic push_word(rar_pkg::op_e op, int an, int ad, int bn, int bd);
    frac_word_t w;
    w.op    = op;
    w.a_num = DW'(an);
    w.a_den = DW'(ad);
    w.b_num = DW'(bn);
    w.b_den = DW'(bd);
    word_q.push_back(w);
    pushed_count++;
  endtask

  // sample handshakes and check results at the rising edge
  always @(posedge clk_i) begin
    frac_word_t   seen;
    frac_result_t want;
    word_taken = rst_ni && in_valid_i && !in_stall_o;
    if (word_taken) begin
      seen.op    = rar_pkg::op_e'(op_i);
      seen.a_num = a_num_i;
      seen.a_den = a_den_i;
      seen.b_num = b_num_i;
      seen.b_den = b_den_i;
      fraction_q.push_back(reduce_fraction(seen));
    end
    res_taken = rst_ni && out_valid_o && !out_stall_i;
    if (res_taken) begin
      checked_count++;
      if (fraction_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result %0d/%0d err %0b", res_num_o, res_den_o, div_error_o);
      end else begin
        want = fraction_q.pop_front();
        if (res_num_o !== want.num || res_den_o !== want.den || div_error_o !== want.err)
        begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"mismatch op %s %0d/%0d , %0d/%0d: ",
                      "expected %0d/%0d err %0b, got %0d/%0d err %0b"},
                     want.src.op.name(), want.src.a_num, want.src.a_den,
                     want.src.b_num, want.src.b_den, want.num, want.den, want.err,
                     res_num_o, res_den_o, div_error_o);
        end
      end
    end
  end

  // drive words and back-pressure at the falling edge
  bit         in_burst  = 1'b0;
  bit         out_burst = 1'b0;
  bit         out_armed = 1'b0;
  int         in_gap    = 0;
  int         out_hold  = 0;
  frac_word_t cur_word;

  always @(negedge clk_i) begin
    bit next_valid;
    bit next_stall;
    if (rst_ni) begin
      // input side: gap after each accepted word, then the next one
      next_valid = in_valid_i;
      if (in_valid_i && word_taken) begin
        next_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          op_i    <= cur_word.op;
          a_num_i <= cur_word.a_num;
          a_den_i <= cur_word.a_den;
          b_num_i <= cur_word.b_num;
          b_den_i <= cur_word.b_den;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;

      // output side: hold each result a random number of cycles
      if (res_taken) begin
        out_armed = 1'b0;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      end
      if (out_valid_o && !out_armed) begin
        out_armed = 1'b1;
        out_hold  = out_burst ? 0 : $urandom_range(0, 4);
      end
      if (out_valid_o) begin
        next_stall = (out_hold > 0);
        if (out_hold > 0) out_hold--;
      end else begin
        next_stall = !out_burst && ($urandom_range(0, 3) == 0);
      end
      out_stall_i <= next_stall;
    end
  end

  // stimulus and end of run
  initial begin
    // extremes, every operation, zero denominators and zero numerators
    push_word(rar_pkg::OP_ADD, 1, 2, 1, 3);
    push_word(rar_pkg::OP_SUB, 1, 2, 1, 2);
    push_word(rar_pkg::OP_MUL, 2, 4, 3, 9);
    push_word(rar_pkg::OP_DIV, 3, 4, 9, 8);
    push_word(rar_pkg::OP_ADD, -32768, -32768, -32768, -32768);
    push_word(rar_pkg::OP_SUB, -32768, 32767, 32767, -32768);
    push_word(rar_pkg::OP_MUL, -32768, 32767, -32768, 32767);
    push_word(rar_pkg::OP_DIV, 32767, -32768, -32768, 32767);
    push_word(rar_pkg::OP_ADD, 32767, 32767, 32767, 32767);
    push_word(rar_pkg::OP_SUB, -32768, 1, 32767, 1);
    push_word(rar_pkg::OP_ADD, 5, 0, 1, 3);
    push_word(rar_pkg::OP_SUB, 1, 3, 5, 0);
    push_word(rar_pkg::OP_MUL, 0, 0, 0, 0);
    push_word(rar_pkg::OP_DIV, 7, 3, 0, 5);
    push_word(rar_pkg::OP_DIV, 0, 3, 0, -5);
    push_word(rar_pkg::OP_MUL, 0, 7, 4, -9);
    push_word(rar_pkg::OP_ADD, 0, -3, 0, 5);
    push_word(rar_pkg::OP_SUB, 3, -4, 3, -4);
    push_word(rar_pkg::OP_MUL, 6, -4, 2, 3);
    push_word(rar_pkg::OP_DIV, -6, 4, -2, 3);
    push_word(rar_pkg::OP_ADD, 1, -1, -1, 1);
    push_word(rar_pkg::OP_MUL, -1, -1, -1, -1);
    push_word(rar_pkg::OP_DIV, 1024, 3072, -512, 256);
    push_word(rar_pkg::OP_SUB, -32767, -32768, 32767, 32767);
    for (int i = 0; i < RANDOM_WORDS; i++)
      push_word(rar_pkg::op_e'($urandom_range(0, 3)), pick_part(), pick_part(),
                pick_part(), pick_part());

    repeat (5) @(posedge clk_i);
    #2 rst_ni = 1'b1;

    // every word sent must come back as a result
    while (checked_count < pushed_count)
      @(negedge clk_i);
    repeat (END_WAIT) @(negedge clk_i);

    if (fail_count == 0 && fraction_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rar_pkg.sv
hdl/rar_reduce.sv
hdl/rational_arith_reduce_unit.sv
test/rational_arith_reduce_unit_test.sv
